// ===== hw/rtl/pal_pkg.sv =====
`default_nettype none
package pal_pkg;

   localparam int WORD_W       = 32;
   localparam int POS_W        = 7;
   localparam int KIND_W       = 2;
   localparam int STATUS_W     = 2;
   localparam int COUNT_W      = 8;
   localparam int CAPACITY_DEF = 128;
   localparam int CAPACITY_MAX = 1024;
   // wide enough for any count up to the largest capacity
   localparam int TGT_W        = $clog2(CAPACITY_MAX + 1);
   localparam int GROUP_SIZE   = 16;

   typedef enum logic [KIND_W-1:0] {
      REQ_APPEND = 2'd0,
      REQ_INSERT = 2'd1,
      REQ_DELETE = 2'd2,
      REQ_READ   = 2'd3
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_WRITE  = 2'd1,
      CELL_INSERT = 2'd2,
      CELL_DELETE = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type               op;
      logic [TGT_W-1:0]          target;
      logic signed [WORD_W-1:0]  value;
   } cell_ctl_type;

endpackage
`default_nettype wire

// ===== hw/rtl/pal_cell.sv =====
`default_nettype none
module pal_cell #(
   parameter int IDX = 0
) (
   input  wire logic                              clock,
   input  wire pal_pkg::cell_ctl_type             ctl,
   input  wire logic signed [pal_pkg::WORD_W-1:0] prev_word,
   input  wire logic signed [pal_pkg::WORD_W-1:0] next_word,
   output logic signed [pal_pkg::WORD_W-1:0]      word,
   output logic signed [pal_pkg::WORD_W-1:0]      hit_word
);
   import pal_pkg::*;

   localparam logic [TGT_W-1:0] MY_IDX = TGT_W'(IDX);

   logic signed [WORD_W-1:0] word_ff;
   logic signed [WORD_W-1:0] word_in;
   logic                     eq;
   logic                     gt;

   assign eq = (MY_IDX == ctl.target);
   assign gt = (MY_IDX > ctl.target);

   always_comb begin
      word_in = word_ff;
      case (ctl.op)
         CELL_WRITE: begin
            if (eq) word_in = ctl.value;
         end
         CELL_INSERT: begin
            // entries at and above the target move up one place
            if (gt) word_in = prev_word;
            else if (eq) word_in = ctl.value;
         end
         CELL_DELETE: begin
            if (gt || eq) word_in = next_word;
         end
         default: word_in = word_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word     = word_ff;
   assign hit_word = eq ? word_ff : '0;

endmodule
`default_nettype wire

// ===== hw/rtl/pal_gather.sv =====
`default_nettype none
module pal_gather #(
   parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
   input  wire logic                                            clock,
   input  wire logic [CAPACITY-1:0][pal_pkg::WORD_W-1:0]        hit_words,
   output logic [pal_pkg::WORD_W-1:0]                           word
);
   import pal_pkg::*;

   localparam int NG = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

   logic [NG-1:0][WORD_W-1:0] grp_ff;
   logic [NG-1:0][WORD_W-1:0] grp_in;

   // first level: or of each group of cells, registered
   always_comb begin
      for (int g = 0; g < NG; g++) begin
         grp_in[g] = '0;
         for (int k = 0; k < GROUP_SIZE; k++) begin
            if (g * GROUP_SIZE + k < CAPACITY)
               grp_in[g] = grp_in[g] | hit_words[g * GROUP_SIZE + k];
         end
      end
   end

   always_ff @(posedge clock) begin
      grp_ff <= grp_in;
   end

   always_comb begin
      word = '0;
      for (int g = 0; g < NG; g++) begin
         word = word | grp_ff[g];
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/positional_array_list_top.sv =====
`default_nettype none
// channel   ports                                          direction  handshake
// request   req_type, req_position, req_value              in         start & !busy
// response  rsp_read_value, rsp_status, rsp_count          out        rsp_strobe, one cycle
//
// a request is taken every cycle; busy is held low
// its response shows on rsp_strobe once it has passed the
// group register of the read-out tree and the response register behind it
// all cells shift in the accept cycle, so the next request sees the new list
// reset clears the entry count and the response valid flags only; cell contents stay until written
// the receiver cannot stall, so no response is ever held
module positional_array_list_top #(
   parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [pal_pkg::KIND_W-1:0]        req_type,
   input  wire logic [pal_pkg::POS_W-1:0]         req_position,
   input  wire logic signed [pal_pkg::WORD_W-1:0] req_value,
   output logic                                   rsp_strobe,
   output logic signed [pal_pkg::WORD_W-1:0]      rsp_read_value,
   output logic [pal_pkg::STATUS_W-1:0]           rsp_status,
   output logic [pal_pkg::COUNT_W-1:0]            rsp_count
);
   import pal_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [TGT_W-1:0] CAP_T = TGT_W'(CAPACITY);

   logic                  accept;
   req_kind_type          kind;
   logic [TGT_W-1:0]      pos_t;
   logic [TGT_W-1:0]      cnt_t;
   logic                  full;
   status_type            status;
   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         count_in;
   cell_ctl_type          ctl;

   logic                  s1_valid_ff;
   logic                  s1_rd_ff;
   status_type            s1_status_ff;
   logic [CW-1:0]         s1_count_ff;

   logic                  rsp_strobe_ff;
   logic [WORD_W-1:0]     rsp_word_ff;
   logic [WORD_W-1:0]     rsp_word_in;
   status_type            rsp_status_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;

   logic signed [WORD_W-1:0]             cell_word [CAPACITY];
   logic signed [WORD_W-1:0]             cell_prev [CAPACITY];
   logic signed [WORD_W-1:0]             cell_next [CAPACITY];
   logic [CAPACITY-1:0][WORD_W-1:0]      hit_words;
   logic [WORD_W-1:0]                    gather_word;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign kind   = req_kind_type'(req_type);
   assign pos_t  = TGT_W'(req_position);
   assign cnt_t  = TGT_W'(count_ff);
   assign full   = (cnt_t == CAP_T);

   always_comb begin
      case (kind)
         REQ_APPEND: status = full ? ST_FULL : ST_OK;
         REQ_INSERT: status = full ? ST_FULL : ((pos_t > cnt_t) ? ST_RANGE : ST_OK);
         default:    status = (pos_t >= cnt_t) ? ST_RANGE : ST_OK;
      endcase
   end

   // broadcast word to the cell row
   always_comb begin
      ctl.op     = CELL_HOLD;
      ctl.target = pos_t;
      ctl.value  = req_value;
      count_in   = count_ff;
      if (accept && status == ST_OK) begin
         case (kind)
            REQ_APPEND: begin
               ctl.op     = CELL_WRITE;
               ctl.target = cnt_t;
               count_in   = count_ff + 1'b1;
            end
            REQ_INSERT: begin
               ctl.op   = CELL_INSERT;
               count_in = count_ff + 1'b1;
            end
            REQ_DELETE: begin
               ctl.op   = CELL_DELETE;
               count_in = count_ff - 1'b1;
            end
            default: ctl.op = CELL_HOLD;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_rd_ff     <= (kind inside {REQ_DELETE, REQ_READ}) && status == ST_OK;
      s1_status_ff <= status;
      s1_count_ff  <= count_in;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign cell_prev[i] = cell_word[i];
      end else begin : g_mid
         assign cell_prev[i] = cell_word[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign cell_next[i] = cell_word[i];
      end else begin : g_rest
         assign cell_next[i] = cell_word[i+1];
      end

      pal_cell #(
         .IDX (i)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .prev_word (cell_prev[i]),
         .next_word (cell_next[i]),
         .word      (cell_word[i]),
         .hit_word  (hit_words[i])
      );
   end

   pal_gather #(
      .CAPACITY (CAPACITY)
   ) u_gather (
      .clock     (clock),
      .hit_words (hit_words),
      .word      (gather_word)
   );

   assign rsp_word_in = s1_rd_ff ? gather_word : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff   <= rsp_word_in;
      rsp_status_ff <= s1_status_ff;
      rsp_count_ff  <= COUNT_W'(s1_count_ff);
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_read_value = rsp_word_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_count      = rsp_count_ff;

   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_strobe)
      else $error("request without response");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      TGT_W'(count_ff) <= CAP_T)
      else $error("entry count beyond capacity");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (count_ff == $past(count_ff) ||
                         count_ff == $past(count_ff) + 1'b1 ||
                         count_ff == $past(count_ff) - 1'b1))
      else $error("entry count jumped");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != ST_OK |-> rsp_read_value == '0)
      else $error("error response carries data");

   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      accept && status == ST_FULL |=> count_ff == $past(count_ff))
      else $error("full list changed");

endmodule
`default_nettype wire

// ===== bench/positional_array_list_top_tb.sv =====
`timescale 1ns / 100ps
module positional_array_list_top_tb;
   import pal_pkg::*;

   localparam int CAPACITY = CAPACITY_DEF;

   typedef struct {
      req_kind_type             kind;
      logic [POS_W-1:0]         pos;
      logic signed [WORD_W-1:0] value;
      bit                       settle;   // hold this word back until all replies are in
   } list_request_type;

   typedef struct {
      logic signed [WORD_W-1:0] read_value;
      status_type               status;
      logic [COUNT_W-1:0]       count;
   } list_reply_type;

   logic                        clock;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic [KIND_W-1:0]           req_type = '0;
   logic [POS_W-1:0]            req_position = '0;
   logic signed [WORD_W-1:0]    req_value = '0;
   logic                        rsp_strobe;
   logic signed [WORD_W-1:0]    rsp_read_value;
   logic [STATUS_W-1:0]         rsp_status;
   logic [COUNT_W-1:0]          rsp_count;

   list_request_type            pending_words[$];
   list_reply_type              expected_replies[$];
   logic signed [WORD_W-1:0]    held_words[CAPACITY];
   int                          held_len = 0;
   int                          planned_len = 0;
   int                          fail_count = 0;
   bit                          presenting = 1'b0;
   bit                          word_taken = 1'b0;
   int                          gap_left = 0;
   int                          burst_left = 0;

   positional_array_list_top #(.CAPACITY(CAPACITY)) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_position   (req_position),
      .req_value      (req_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_count      (rsp_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #400_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // list behavior: apply one request to the held list, return its reply
   function automatic list_reply_type apply_list_op(req_kind_type kind,
                                                    logic [POS_W-1:0] pos,
                                                    logic signed [WORD_W-1:0] value);
      list_reply_type r;
      int             p;
      p = pos;
      r.read_value = '0;
      r.status = ST_OK;
      case (kind)
         REQ_APPEND: begin
            if (held_len >= CAPACITY) r.status = ST_FULL;
            else begin
               held_words[held_len] = value;
               held_len++;
            end
         end
         REQ_INSERT: begin
            if (held_len >= CAPACITY) r.status = ST_FULL;
            else if (p > held_len) r.status = ST_RANGE;
            else begin
               for (int i = held_len; i > p; i--) held_words[i] = held_words[i-1];
               held_words[p] = value;
               held_len++;
            end
         end
         REQ_DELETE: begin
            if (p >= held_len) r.status = ST_RANGE;
            else begin
               r.read_value = held_words[p];
               for (int i = p; i < held_len - 1; i++) held_words[i] = held_words[i+1];
               held_len--;
            end
         end
         default: begin
            if (p >= held_len) r.status = ST_RANGE;
            else r.read_value = held_words[p];
         end
      endcase
      r.count = COUNT_W'(held_len);
      return r;
   endfunction

   task automatic flag_mismatch(string what);
      fail_count++;
      if (fail_count <= 10) $display("%0t: %s", $time, what);
   endtask

   // planned_len tracks the list length the stimulus expects, to aim positions
   task automatic queue_word(req_kind_type kind, int pos, logic signed [WORD_W-1:0] value,
                             bit settle = 1'b0);
      list_request_type w;
      w.kind = kind;
      w.pos = POS_W'(pos);
      w.value = value;
      w.settle = settle;
      pending_words.push_back(w);
      case (kind)
         REQ_APPEND: if (planned_len < CAPACITY) planned_len++;
         REQ_INSERT: if (planned_len < CAPACITY && pos <= planned_len) planned_len++;
         REQ_DELETE: if (pos < planned_len) planned_len--;
         default: ;
      endcase
   endtask

   task automatic queue_random(int w_app, int w_ins, int w_del, int w_rd);
      int                       roll;
      int                       pos;
      bit                       aimed;
      req_kind_type             kind;
      logic signed [WORD_W-1:0] value;
      roll = $urandom_range(0, w_app + w_ins + w_del + w_rd - 1);
      aimed = ($urandom_range(0, 9) < 8);
      if (roll < w_app) kind = REQ_APPEND;
      else if (roll < w_app + w_ins) kind = REQ_INSERT;
      else if (roll < w_app + w_ins + w_del) kind = REQ_DELETE;
      else kind = REQ_READ;
      case ($urandom_range(0, 15))
         0: value = 32'h8000_0000;
         1: value = 32'h7fff_ffff;
         2: value = '0;
         3: value = '1;
         default: value = $urandom;
      endcase
      pos = $urandom_range(0, 127);
      if (kind == REQ_INSERT && planned_len < CAPACITY) begin
         if (aimed || planned_len >= 127) pos = $urandom_range(0, planned_len);
         else pos = $urandom_range(planned_len + 1, 127);
      end else if (kind == REQ_DELETE || kind == REQ_READ) begin
         if (planned_len > 0 && (aimed || planned_len >= 128))
            pos = $urandom_range(0, (planned_len > 128 ? 128 : planned_len) - 1);
         else
            pos = $urandom_range(planned_len, 127);
      end
      queue_word(kind, pos, value);
   endtask

   // driver: one word on the request ports at a time, random gaps between words
   always @(negedge clock) begin
      if (!reset) begin
         if (word_taken) begin
            word_taken = 1'b0;
            presenting = 1'b0;
            if (burst_left > 0) begin
               burst_left--;
               gap_left = 0;
            end else if ($urandom_range(0, 49) == 0) begin
               burst_left = $urandom_range(10, 40);
               gap_left = 0;
            end else begin
               gap_left = $urandom_range(0, 3);
            end
         end
         if (!presenting) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_words.size() > 0 &&
                         !(pending_words[0].settle && expected_replies.size() > 0)) begin
               req_type <= pending_words[0].kind;
               req_position <= pending_words[0].pos;
               req_value <= pending_words[0].value;
               void'(pending_words.pop_front());
               presenting = 1'b1;
            end
         end
         start <= presenting;
      end
   end

   // monitor: check replies, predict on every accepted word
   always @(posedge clock) begin
      list_reply_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            if (expected_replies.size() == 0) begin
               flag_mismatch($sformatf("reply with none pending: value %0d status %0d count %0d",
                                       rsp_read_value, rsp_status, rsp_count));
            end else begin
               want = expected_replies.pop_front();
               if (rsp_read_value !== want.read_value)
                  flag_mismatch($sformatf("read_value expected %0d got %0d",
                                          want.read_value, rsp_read_value));
               if (rsp_status !== want.status)
                  flag_mismatch($sformatf("status expected %0d got %0d", want.status, rsp_status));
               if (rsp_count !== want.count)
                  flag_mismatch($sformatf("count expected %0d got %0d", want.count, rsp_count));
            end
         end
         if (start && !busy) begin
            expected_replies.push_back(apply_list_op(req_kind_type'(req_type), req_position,
                                                     req_value));
            word_taken = 1'b1;
         end
      end
   end

   initial begin
      // short directed run over the corner cases
      queue_word(REQ_READ, 0, 32'h5555_aaaa);     // read on empty list
      queue_word(REQ_DELETE, 0, 0);               // delete on empty list
      queue_word(REQ_DELETE, 127, 0);
      queue_word(REQ_INSERT, 1, 5);               // insert past the end
      queue_word(REQ_INSERT, 0, 32'h7fff_ffff);   // insert at count acts as append
      queue_word(REQ_APPEND, 127, 32'h8000_0000); // position ignored on append
      queue_word(REQ_APPEND, 0, 0);
      queue_word(REQ_INSERT, 1, -1);              // insert in the middle
      queue_word(REQ_INSERT, 4, 32'h1234_5678);
      queue_word(REQ_INSERT, 6, 1);
      for (int i = 0; i < 6; i++) queue_word(REQ_READ, i, 32'haaaa_5555);
      queue_word(REQ_DELETE, 2, 0);
      queue_word(REQ_DELETE, 3, 0);               // delete the last word
      queue_word(REQ_READ, 127, 0);
      queue_word(REQ_DELETE, 0, 0);

      for (int i = 0; i < 180; i++) queue_random(3, 3, 3, 3);
      while (planned_len < CAPACITY) queue_random(4, 4, 1, 2);

      // full list: append and insert report full, whatever the position
      queue_word(REQ_APPEND, 0, 32'h0bad_0001, 1'b1);
      queue_word(REQ_INSERT, 0, 32'h0bad_0002);
      queue_word(REQ_INSERT, 127, 32'h0bad_0003);
      queue_word(REQ_READ, 127, 0);
      queue_word(REQ_DELETE, 127, 0);
      queue_word(REQ_INSERT, 127, 32'h7fff_fffe);
      queue_word(REQ_READ, 127, 0);
      queue_word(REQ_DELETE, 0, 0);
      queue_word(REQ_APPEND, 0, 32'h8000_0001);

      while (planned_len > 0) queue_random(0, 1, 6, 2);
      for (int i = 0; i < 6; i++) queue_random(0, 1, 1, 1);
      queue_word(REQ_APPEND, 0, $urandom, 1'b1);
      for (int i = 0; i < 200; i++) queue_random(3, 3, 2, 3);

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      while (pending_words.size() > 0 || presenting) @(posedge clock);
      for (int i = 0; i < 200 && expected_replies.size() > 0; i++) @(posedge clock);
      repeat (8) @(posedge clock);
      if (expected_replies.size() > 0)
         flag_mismatch($sformatf("%0d replies never arrived", expected_replies.size()));
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
